/* hdl/rmsp_pkg.sv */
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared constants and types for the RMSProp parameter update unit.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  // Mean square store geometry
  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);

  // Field and register widths
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Stream widths
  localparam int IN_FIELDS_W = IDX_W + 2 * DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * DATA_W;
  localparam int OUT_TUSER_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] LR_RESET    = 16'd66;
  localparam logic [CFG_W-1:0] DECAY_RESET = 16'd58982;
  localparam logic [CFG_W-1:0] EPS_RESET   = 16'd1;

  // 1.0 in unsigned Q1.16
  localparam logic [CFG_W:0] ONE_Q016 = 17'h10000;

  // Pipeline shape of the square root and the divider
  localparam int SQ_STAGES = 5;
  localparam int SQ_STEPS  = 5;
  localparam int DV_STAGES = 11;
  localparam int DV_STEPS  = 3;

  // Result flags, highest bit first
  typedef struct packed {
    logic zero_divisor;
    logic saturated;
  } flags_t;

endpackage

/* hdl/rmsp_ram.sv */
// ----------------------------------------------------------------------------
// rmsp_ram
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module rmsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rmsprop_param_update_unit.sv */
// ----------------------------------------------------------------------------
// rmsprop_param_update_unit
// RMSProp update of one parameter element per request, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and presents
// each result on the output in order (23 register stages, the first loaded at
// acceptance). The mean square update (one 32x16 multiply and add, with
// forwarding from the two following stages) closes in a single stage, so
// requests that hit the same element back to back run at full rate. The square
// root takes 5 stages and the divider 11 stages; a stall at the output holds
// the whole pipeline. After reset the 1024-entry mean square store is cleared,
// one entry per cycle; requests are refused during that pass while
// configuration writes are taken.
module rmsprop_param_update_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmsp_pkg::CFG_W-1:0]       cfg_data,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // elem_index[9:0], grad_value[41:10], param_in[73:42], zero pad[79:74]
  input  logic [rmsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // param_out[31:0], mean_square_out[63:32]
  output logic [rmsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated[0], zero_divisor[1]
  output logic [rmsp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int DW = rmsp_pkg::DATA_W;
  localparam int IW = rmsp_pkg::IDX_W;
  localparam int SQ = rmsp_pkg::SQ_STAGES;
  localparam int DV = rmsp_pkg::DV_STAGES;

  typedef struct packed {
    logic          gneg;
    logic [31:0]   p;
    logic [31:0]   ms;
    logic          sat;
    logic          zero;
    logic [47:0]   num;
    logic [49:0]   y;
    logic [26:0]   rem;
    logic [24:0]   root;
  } sq_t;

  typedef struct packed {
    logic          gneg;
    logic [31:0]   p;
    logic [31:0]   ms;
    logic          sat;
    logic          zero;
    logic          ovf;
    logic [24:0]   den;
    logic [32:0]   nl;
    logic [24:0]   rem;
    logic [32:0]   q;
  } dv_t;

  // Square root: two radicand bits per step
  function automatic sq_t sq_steps(sq_t a);
    sq_t         r;
    logic [28:0] rt;
    logic [28:0] tr;
    r = a;
    for (int i = 0; i < rmsp_pkg::SQ_STEPS; i++) begin
      rt  = {r.rem, r.y[49:48]};
      tr  = {2'b00, r.root, 2'b01};
      r.y = {r.y[47:0], 2'b00};
      if (rt >= tr) begin
        rt     = rt - tr;
        r.root = {r.root[23:0], 1'b1};
      end else begin
        r.root = {r.root[23:0], 1'b0};
      end
      r.rem = rt[26:0];
    end
    return r;
  endfunction

  // Restoring division: one quotient bit per step
  function automatic dv_t dv_steps(dv_t a);
    dv_t         r;
    logic [25:0] rt;
    r = a;
    for (int i = 0; i < rmsp_pkg::DV_STEPS; i++) begin
      rt   = {r.rem, r.nl[32]};
      r.nl = {r.nl[31:0], 1'b0};
      if (rt >= {1'b0, r.den}) begin
        rt  = rt - {1'b0, r.den};
        r.q = {r.q[31:0], 1'b1};
      end else begin
        r.q = {r.q[31:0], 1'b0};
      end
      r.rem = rt[24:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [rmsp_pkg::CFG_W-1:0] step_size;
  logic [rmsp_pkg::CFG_W-1:0] decay;
  logic [rmsp_pkg::CFG_W-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= rmsp_pkg::LR_RESET;
      decay     <= rmsp_pkg::DECAY_RESET;
      epsilon   <= rmsp_pkg::EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmsp_pkg::REG_STEP_SIZE: step_size <= cfg_data;
        rmsp_pkg::REG_DECAY:     decay     <= cfg_data;
        rmsp_pkg::REG_EPSILON:   epsilon   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass over the store after reset
  logic          clearing;
  logic [IW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(rmsp_pkg::DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Global advance: hold everything while a result waits
  logic adv;
  logic in_fire;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !clearing;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Valid bits
  logic [6:1]  v_s;
  logic [SQ:1] sq_v;
  logic [DV:1] dv_v;
  logic        out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s   <= '0;
      sq_v  <= '0;
      dv_v  <= '0;
      out_v <= 1'b0;
    end else if (adv) begin
      v_s   <= {v_s[5:1], in_fire};
      sq_v  <= {sq_v[SQ-1:1], v_s[6]};
      dv_v  <= {dv_v[DV-1:1], sq_v[SQ]};
      out_v <= dv_v[DV];
    end
  end

  // Front stages: capture, magnitude, square, weight, store read
  logic [IW-1:0] idx1, idx2, idx3, idx4, idx5, idx6, idx7;
  logic [DW-1:0] g1, p1, p2, p3, p4, p5, p6;
  logic          gneg2, gneg3, gneg4, gneg5, gneg6;
  logic [DW-1:0] gmag1, gmag2, gmag3, gmag4, gmag5, gmag6;
  logic [63:0]   gsq2;
  logic [47:0]   g2_3;
  logic [16:0]   w3;
  logic [48:0]   wlo3, wlo4;
  logic [32:0]   whi3, whi4;
  logic [63:0]   t4, t5;
  logic [DW-1:0] ms_rd, msrd5, ms_old5, ms_new5, ms6;
  logic [47:0]   prod5;
  logic [63:0]   acc5;
  logic          sat5, sat6;

  // Square root stage registers
  sq_t sq_in [0:SQ-1];
  sq_t sq_q  [1:SQ];

  assign gmag1 = g1[DW-1] ? (~g1 + 1'b1) : g1;
  assign gsq2  = gmag2 * gmag2;
  assign w3    = rmsp_pkg::ONE_Q016 - {1'b0, decay};
  assign wlo3  = w3 * g2_3[31:0];
  assign whi3  = w3 * g2_3[47:32];
  assign t4    = 64'({whi4, 32'h0}) + 64'(wlo4);

  // Forward results not yet visible in the store read
  always_comb begin
    priority if (v_s[6] && idx6 == idx5) begin
      ms_old5 = ms6;
    end else if (sq_v[1] && idx7 == idx5) begin
      ms_old5 = sq_q[1].ms;
    end else begin
      ms_old5 = msrd5;
    end
  end

  assign prod5   = ms_old5 * decay;
  assign acc5    = 64'(prod5) + t5;
  assign sat5    = |acc5[63:48];
  assign ms_new5 = sat5 ? '1 : acc5[47:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1  <= s_axis_tdata[IW-1:0];
      g1    <= s_axis_tdata[IW +: DW];
      p1    <= s_axis_tdata[IW+DW +: DW];
      idx2  <= idx1;
      gneg2 <= g1[DW-1];
      gmag2 <= gmag1;
      p2    <= p1;
      idx3  <= idx2;
      gneg3 <= gneg2;
      gmag3 <= gmag2;
      p3    <= p2;
      g2_3  <= gsq2[63:16];
      idx4  <= idx3;
      gneg4 <= gneg3;
      gmag4 <= gmag3;
      p4    <= p3;
      wlo4  <= wlo3;
      whi4  <= whi3;
      idx5  <= idx4;
      gneg5 <= gneg4;
      gmag5 <= gmag4;
      p5    <= p4;
      t5    <= t4;
      msrd5 <= ms_rd;
      idx6  <= idx5;
      gneg6 <= gneg5;
      gmag6 <= gmag5;
      p6    <= p5;
      ms6   <= ms_new5;
      sat6  <= sat5;
      idx7  <= idx6;
    end
  end

  // Mean square store; re-read the waiting element while stalled
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;

  assign ram_we    = clearing || (adv && v_s[5]);
  assign ram_waddr = clearing ? clr_addr : idx5;
  assign ram_wdata = clearing ? '0 : ms_new5;
  assign ram_raddr = adv ? idx3 : idx4;

  rmsp_ram #(
    .WIDTH (DW),
    .DEPTH (rmsp_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ms_rd)
  );

  // Denominator radicand and numerator
  logic [32:0] x6;
  logic [47:0] num6;
  sq_t         sq_ld;

  assign x6   = {1'b0, ms6} + {17'h0, epsilon};
  assign num6 = step_size * gmag6;

  always_comb begin
    sq_ld      = '0;
    sq_ld.gneg = gneg6;
    sq_ld.p    = p6;
    sq_ld.ms   = ms6;
    sq_ld.sat  = sat6;
    sq_ld.zero = (x6 == '0);
    sq_ld.num  = num6;
    sq_ld.y    = {1'b0, x6, 16'h0};
  end

  // Square root stages
  assign sq_in[0] = sq_ld;

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    if (k > 0) begin : g_link
      assign sq_in[k] = sq_q[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_q[k+1] <= sq_steps(sq_in[k]);
      end
    end
  end

  // Divider load: flag quotients of 2^33 or more, they always clip
  dv_t dv_ld;

  always_comb begin
    dv_ld      = '0;
    dv_ld.gneg = sq_q[SQ].gneg;
    dv_ld.p    = sq_q[SQ].p;
    dv_ld.ms   = sq_q[SQ].ms;
    dv_ld.sat  = sq_q[SQ].sat;
    dv_ld.zero = sq_q[SQ].zero;
    dv_ld.den  = sq_q[SQ].root;
    dv_ld.ovf  = 25'(sq_q[SQ].num[47:33]) >= sq_q[SQ].root;
    dv_ld.rem  = 25'(sq_q[SQ].num[47:33]);
    dv_ld.nl   = sq_q[SQ].num[32:0];
  end

  // Divider stages
  dv_t dv_in [0:DV-1];
  dv_t dv_q  [1:DV];

  assign dv_in[0] = dv_ld;

  for (genvar k = 0; k < DV; k++) begin : g_dv
    if (k > 0) begin : g_link
      assign dv_in[k] = dv_q[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_q[k+1] <= dv_steps(dv_in[k]);
      end
    end
  end

  // Apply the step and clip to the signed range; a zero divisor passes the parameter through
  logic [34:0]      pe, qe, sum;
  logic             clip, clip_neg;
  logic [DW-1:0]    res;
  rmsp_pkg::flags_t flags;

  assign pe       = {{3{dv_q[DV].p[DW-1]}}, dv_q[DV].p};
  assign qe       = {2'b00, dv_q[DV].q};
  assign sum      = dv_q[DV].gneg ? (pe + qe) : (pe - qe);
  assign clip     = dv_q[DV].ovf || (sum[34:31] != {4{sum[34]}});
  assign clip_neg = dv_q[DV].ovf ? !dv_q[DV].gneg : sum[34];

  always_comb begin
    if (dv_q[DV].zero) begin
      res = dv_q[DV].p;
    end else if (clip) begin
      res = clip_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = sum[31:0];
    end
    flags.zero_divisor = dv_q[DV].zero;
    flags.saturated    = dv_q[DV].sat || (!dv_q[DV].zero && clip);
  end

  // Output register
  logic [DW-1:0]    out_param;
  logic [DW-1:0]    out_ms;
  rmsp_pkg::flags_t out_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_param <= res;
      out_ms    <= dv_q[DV].ms;
      out_flags <= flags;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {out_ms, out_param};
  assign m_axis_tuser  = out_flags;

endmodule

/* hdl/rmsp_check.sv */
// ----------------------------------------------------------------------------
// rmsp_check
// Port-level checks for the RMSProp parameter update unit.
// ----------------------------------------------------------------------------
module rmsp_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rmsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rmsp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // Store clearing refuses requests right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during store clearing");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("waiting result changed");

  // A stalled output refuses new requests
  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

  // Zero divisor only with a zero mean square and no clipping
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[63:32] == 32'h0 && !m_axis_tuser[0])
    else $error("zero divisor with nonzero mean square");

endmodule

bind rmsprop_param_update_unit rmsp_check u_check (.*);
